>>> rtl/rleseg_pkg.sv
// Package for the PackBits segment decoder: widths, decode modes, error codes,
// register indexes and the structs passed between the top level and the step logic.
// No dependencies.
package rleseg_pkg;

   localparam int CFG_BITS  = 24;             // width of the 24-bit registers
   localparam int POS_BITS  = CFG_BITS + 1;   // position may step past the buffer end
   localparam int STRIDE_BITS = 5;
   localparam int BYTE_BITS = 8;

   typedef enum logic [1:0] {
      MODE_CONTROL = 2'd0,
      MODE_LITERAL = 2'd1,
      MODE_REPEAT  = 2'd2,
      MODE_STOPPED = 2'd3
   } decode_mode_type;

   typedef enum logic [1:0] {
      ERR_NONE           = 2'd0,
      ERR_LITERAL_INPUT  = 2'd1,
      ERR_LITERAL_OUTPUT = 2'd2,
      ERR_REPEAT_OUTPUT  = 2'd3
   } error_code_type;

   typedef enum logic [1:0] {
      REG_START_POSITION = 2'd0,
      REG_SAMPLE_STRIDE  = 2'd1,
      REG_OUTPUT_LENGTH  = 2'd2,
      REG_SEGMENT_LENGTH = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [CFG_BITS-1:0]    start_position;
      logic [STRIDE_BITS-1:0] sample_stride;
      logic [CFG_BITS-1:0]    output_length;
      logic [CFG_BITS-1:0]    segment_length;
   } cfg_type;

   typedef struct packed {
      decode_mode_type        mode;
      logic [CFG_BITS-1:0]    bytes_consumed;
      logic [POS_BITS-1:0]    out_position;
      logic [BYTE_BITS-1:0]   run_remaining;
      logic [BYTE_BITS-1:0]   repeat_length;
   } state_type;

   typedef struct packed {
      logic                   valid;
      logic [POS_BITS-1:0]    address;
      logic [BYTE_BITS-1:0]   value;
      logic [BYTE_BITS-1:0]   count;
      error_code_type         error;
      logic                   done;
   } result_type;

endpackage

>>> rtl/rle_segment_decoder.sv
// PackBits segment decoder top level: config registers, decode state and result register.
// Depends on rleseg_pkg and rleseg_step.
//
// Usage: program start_position, sample_stride, output_length and segment_length through
// the csr_ port (index 0..3) while the block is idle; every write restarts the segment.
// Then stream the compressed bytes on req_ (valid/stall). Each accepted byte yields at
// most one item on rsp_: a counted write (address, value, repeat count) plus an error
// code and a segment_done flag. Control bytes give items with count 0; a repeat run
// comes out as one item carrying its whole count.
// Latency: the item for a byte is on rsp_ the cycle after the byte is accepted.
// Throughput: one byte per cycle while req_stall is low; the decode step is a single
// pass through rleseg_step between the state registers and the result register.
// Once decoding has stopped (done, output full or an error), further bytes are accepted
// and dropped without any item until the next register write or reset.
// Reset loads the register defaults (stride 1, all else 0) and restarts decoding.
// When rsp_stall holds a waiting item, req_stall is raised so no byte is lost.
// POSITION_BITS limits the significant bits of the reported write address.
module rle_segment_decoder #(
   parameter int POSITION_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_write_address,
   output logic [7:0]  rsp_byte_value,
   output logic [7:0]  rsp_repeat_count,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_segment_done,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_write_data
);

   localparam int CW = rleseg_pkg::CFG_BITS;
   localparam int SW = rleseg_pkg::STRIDE_BITS;
   localparam int ADDR_BITS = (POSITION_BITS < CW) ? POSITION_BITS : CW;
   localparam logic [CW-1:0] ADDR_MASK = CW'((33'd1 << ADDR_BITS) - 33'd1);

   rleseg_pkg::cfg_type    cfg_ff, cfg_in;
   rleseg_pkg::state_type  state_ff, state_in;
   rleseg_pkg::state_type  step_state;
   rleseg_pkg::result_type step_result;
   rleseg_pkg::state_type  restart_state;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]          rsp_address_ff;
   logic [7:0]             rsp_value_ff;
   logic [7:0]             rsp_count_ff;
   logic [1:0]             rsp_error_ff;
   logic                   rsp_done_ff;
   logic                   req_accept;
   logic                   rsp_load;

   rleseg_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .data_byte  (req_data_byte),
      .next_state (step_state),
      .result     (step_result)
   );

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = req_accept && step_result.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (rleseg_pkg::reg_index_type'(csr_index))
            rleseg_pkg::REG_START_POSITION: cfg_in.start_position = csr_write_data;
            rleseg_pkg::REG_SAMPLE_STRIDE:  cfg_in.sample_stride  = csr_write_data[SW-1:0];
            rleseg_pkg::REG_OUTPUT_LENGTH:  cfg_in.output_length  = csr_write_data;
            rleseg_pkg::REG_SEGMENT_LENGTH: cfg_in.segment_length = csr_write_data;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      restart_state                = '0;
      restart_state.mode           = rleseg_pkg::MODE_CONTROL;
      restart_state.out_position   = {1'b0, cfg_in.start_position};
   end

   always_comb begin
      state_in = state_ff;
      if (csr_write_enable) begin
         state_in = restart_state;
      end else if (req_accept) begin
         state_in = step_state;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_position <= '0;
         cfg_ff.sample_stride  <= SW'(1);
         cfg_ff.output_length  <= '0;
         cfg_ff.segment_length <= '0;
         // all-zero state is control mode at position 0
         state_ff              <= '0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: load only with a new item, hold while stalled
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_address_ff <= step_result.address[CW-1:0] & ADDR_MASK;
         rsp_value_ff   <= step_result.value;
         rsp_count_ff   <= step_result.count;
         rsp_error_ff   <= step_result.error;
         rsp_done_ff    <= step_result.done;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = rsp_address_ff;
   assign rsp_byte_value    = rsp_value_ff;
   assign rsp_repeat_count  = rsp_count_ff;
   assign rsp_error_code    = rsp_error_ff;
   assign rsp_segment_done  = rsp_done_ff;

   // stopped decoding leaves only through a register write
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode == rleseg_pkg::MODE_STOPPED && !csr_write_enable)
      |=> state_ff.mode == rleseg_pkg::MODE_STOPPED)
      else $error("decoder left stopped mode without a register write");

   // any error ends the segment
   a_error_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != rleseg_pkg::ERR_NONE) |-> rsp_segment_done)
      else $error("error item without segment_done");

   // a counted write is never an error item
   a_write_no_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_repeat_count != '0) |-> rsp_error_code == rleseg_pkg::ERR_NONE)
      else $error("write item carries an error code");

   // a literal run always has bytes left while in literal mode
   a_literal_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode == rleseg_pkg::MODE_LITERAL) |-> state_ff.run_remaining != '0)
      else $error("literal mode with empty run");

   // an item accepted while stopped never loads a result
   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && state_ff.mode == rleseg_pkg::MODE_STOPPED) |-> !rsp_load)
      else $error("result produced while stopped");

   // in repeat mode the pending run is at least two long
   a_repeat_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode == rleseg_pkg::MODE_REPEAT) |-> state_ff.repeat_length >= 8'd2)
      else $error("repeat mode with run shorter than two");

endmodule

>>> rtl/rleseg_step.sv
// Next-state and result logic for one compressed byte of the PackBits decoder.
// Purely combinational; uses rleseg_pkg for the state, config and result structs.
module rleseg_step (
   input  rleseg_pkg::cfg_type    cfg,
   input  rleseg_pkg::state_type  state,
   input  logic [rleseg_pkg::BYTE_BITS-1:0] data_byte,
   output rleseg_pkg::state_type  next_state,
   output rleseg_pkg::result_type result
);

   localparam int CW = rleseg_pkg::CFG_BITS;
   localparam int PW = rleseg_pkg::POS_BITS;
   localparam int BW = rleseg_pkg::BYTE_BITS;
   localparam int SW = rleseg_pkg::STRIDE_BITS;

   logic [PW-1:0]      consumed_inc;
   logic [PW-1:0]      consumed_inc2;
   logic               exhausted;
   logic               pos_full;
   logic               tail_reached;
   logic               is_literal;
   logic               is_skip;
   logic [BW-1:0]      neg_byte;
   logic [BW-2:0]      span_units;
   logic [BW+SW-2:0]   span_offset;
   logic [PW:0]        last_pos;
   logic               over_output;
   logic [CW-1:0]      seg_left;
   logic [BW-1:0]      literal_len;
   logic               literal_short;
   logic [BW-1:0]      repeat_len_ctl;
   logic               repeat_no_value;
   logic               ctl_end;
   logic [PW-1:0]      pos_plus_stride;
   logic [BW-1:0]      run_dec;
   logic               lit_end;
   logic [BW+SW-1:0]   rep_offset;
   logic [PW-1:0]      pos_plus_rep;
   logic               rep_end;

   assign consumed_inc  = {1'b0, state.bytes_consumed} + PW'(1);
   assign consumed_inc2 = {1'b0, state.bytes_consumed} + PW'(2);
   assign exhausted     = (state.bytes_consumed >= cfg.segment_length) || pos_full;
   assign pos_full      = state.out_position >= {1'b0, cfg.output_length};
   // at most one compressed byte left once this byte is counted
   assign tail_reached  = consumed_inc2 >= {1'b0, cfg.segment_length};

   // control byte decode
   assign is_literal     = !data_byte[BW-1];
   assign is_skip        = data_byte == {1'b1, {(BW-1){1'b0}}};
   assign neg_byte       = BW'(0) - data_byte;
   assign span_units     = is_literal ? data_byte[BW-2:0] : neg_byte[BW-2:0];
   assign span_offset    = span_units * cfg.sample_stride;
   assign last_pos       = {1'b0, state.out_position} + (PW+1)'(span_offset);
   assign over_output    = last_pos >= (PW+1)'(cfg.output_length);
   assign seg_left       = cfg.segment_length - consumed_inc[CW-1:0];
   assign literal_len    = {1'b0, data_byte[BW-2:0]} + BW'(1);
   assign literal_short  = seg_left < CW'(literal_len);
   assign repeat_len_ctl = neg_byte + BW'(1);
   assign repeat_no_value = consumed_inc >= {1'b0, cfg.segment_length};
   assign ctl_end        = tail_reached || pos_full;

   // literal byte
   assign pos_plus_stride = state.out_position + PW'(cfg.sample_stride);
   assign run_dec         = (state.run_remaining != '0) ? state.run_remaining - BW'(1) : '0;
   assign lit_end         = tail_reached || (pos_plus_stride >= {1'b0, cfg.output_length});

   // repeat value byte
   assign rep_offset   = state.repeat_length * cfg.sample_stride;
   assign pos_plus_rep = state.out_position + PW'(rep_offset);
   assign rep_end      = tail_reached || (pos_plus_rep >= {1'b0, cfg.output_length});

   always_comb begin
      next_state = state;
      unique case (state.mode)
         rleseg_pkg::MODE_CONTROL: begin
            if (exhausted) begin
               next_state.mode = rleseg_pkg::MODE_STOPPED;
            end else begin
               next_state.bytes_consumed = consumed_inc[CW-1:0];
               if (is_literal) begin
                  if (literal_short || over_output) begin
                     next_state.mode = rleseg_pkg::MODE_STOPPED;
                  end else begin
                     next_state.mode          = rleseg_pkg::MODE_LITERAL;
                     next_state.run_remaining = literal_len;
                  end
               end else if (is_skip) begin
                  next_state.mode = ctl_end ? rleseg_pkg::MODE_STOPPED
                                            : rleseg_pkg::MODE_CONTROL;
               end else if (over_output || repeat_no_value) begin
                  next_state.mode = rleseg_pkg::MODE_STOPPED;
               end else begin
                  next_state.mode          = rleseg_pkg::MODE_REPEAT;
                  next_state.repeat_length = repeat_len_ctl;
               end
            end
         end
         rleseg_pkg::MODE_LITERAL: begin
            next_state.bytes_consumed = consumed_inc[CW-1:0];
            next_state.out_position   = pos_plus_stride;
            next_state.run_remaining  = run_dec;
            if (run_dec == '0) begin
               next_state.mode = lit_end ? rleseg_pkg::MODE_STOPPED
                                         : rleseg_pkg::MODE_CONTROL;
            end
         end
         rleseg_pkg::MODE_REPEAT: begin
            next_state.bytes_consumed = consumed_inc[CW-1:0];
            next_state.out_position   = pos_plus_rep;
            next_state.repeat_length  = '0;
            next_state.mode = rep_end ? rleseg_pkg::MODE_STOPPED
                                      : rleseg_pkg::MODE_CONTROL;
         end
         rleseg_pkg::MODE_STOPPED: begin
            next_state = state;
         end
         default: begin
            next_state = state;
         end
      endcase
   end

   always_comb begin
      result         = '0;
      result.valid   = 1'b1;
      result.address = state.out_position;
      result.error   = rleseg_pkg::ERR_NONE;
      unique case (state.mode)
         rleseg_pkg::MODE_CONTROL: begin
            if (exhausted) begin
               result.done = 1'b1;
            end else if (is_literal) begin
               if (literal_short) begin
                  result.error = rleseg_pkg::ERR_LITERAL_INPUT;
                  result.done  = 1'b1;
               end else if (over_output) begin
                  result.error = rleseg_pkg::ERR_LITERAL_OUTPUT;
                  result.done  = 1'b1;
               end
            end else if (is_skip) begin
               result.done = ctl_end;
            end else if (over_output) begin
               result.error = rleseg_pkg::ERR_REPEAT_OUTPUT;
               result.done  = 1'b1;
            end else begin
               result.done = repeat_no_value;
            end
         end
         rleseg_pkg::MODE_LITERAL: begin
            result.value = data_byte;
            result.count = BW'(1);
            result.done  = (run_dec == '0) && lit_end;
         end
         rleseg_pkg::MODE_REPEAT: begin
            result.value = data_byte;
            result.count = state.repeat_length;
            result.done  = rep_end;
         end
         rleseg_pkg::MODE_STOPPED: begin
            result.valid = 1'b0;
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase
   end

endmodule
